FILE: rtl/core/meu_pkg.sv
// Shared definitions for the modular exponentiation unit.
// Holds the configuration register indexes and the multiplier status type.
// No dependencies.
`default_nettype none

package meu_pkg;

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODULUS  = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/meu_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, double and add.
// Depends on meu_pkg for the status type.
`default_nettype none

module meu_mulmod #(
    parameter int WORD_BITS = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    start,
    input  wire [WORD_BITS-1:0]    op_a,
    input  wire [WORD_BITS-1:0]    op_b,
    input  wire [WORD_BITS-1:0]    modulus,
    output meu_pkg::mul_status_t   status,
    output logic [WORD_BITS-1:0]   product
);
    import meu_pkg::*;

    localparam int CW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [WORD_BITS+1:0] addend;
    logic [WORD_BITS+1:0] sum;
    logic [WORD_BITS+1:0] n_one;
    logic [WORD_BITS+1:0] n_two;

    always_comb
    begin
        addend = b_reg[WORD_BITS-1] ? {2'b00, a_reg} : '0;
        sum    = {1'b0, acc_reg, 1'b0} + addend;
        n_one  = {2'b00, modulus};
        n_two  = {1'b0, modulus, 1'b0};
        if (sum >= n_two)
        begin
            acc_next = WORD_BITS'(sum - n_two);
        end
        else if (sum >= n_one)
        begin
            acc_next = WORD_BITS'(sum - n_one);
        end
        else
        begin
            acc_next = sum[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WORD_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[WORD_BITS-2:0], 1'b0};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign product     = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: stream ports, registers and sequencer.
// Depends on meu_pkg and meu_mulmod.
// Each request takes a base word and returns base to the configured exponent
// modulo the configured modulus, using left-to-right square-and-multiply over all
// WORD_BITS exponent bits on one bit-serial modular multiplier that handles one
// multiplier bit per cycle. The multiplier is used first to reduce the base and
// then once or twice per exponent bit, so the time a request takes is set by the
// multiplier and grows with the number of set exponent bits.
// A zero exponent returns 1. One request is worked at a time;
// a finished result waits in the output register while the next request starts.
// A zero write to the modulus is ignored.
`default_nettype none

module modular_exponentiation_unit #(
    parameter int WORD_BITS = 64
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: base_value.
    input  wire [((WORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // Fields from bit 0: power_result.
    output logic [((WORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire [meu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire [WORD_BITS-1:0]               cfg_data
);
    import meu_pkg::*;

    localparam int DATA_BITS = ((WORD_BITS + 7) / 8) * 8;
    localparam int CW        = $clog2(WORD_BITS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_MULT   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [WORD_BITS-1:0] ONE = {{(WORD_BITS-1){1'b0}}, 1'b1};

    logic [2:0]           state_reg;
    logic [WORD_BITS-1:0] exponent_reg;
    logic [WORD_BITS-1:0] modulus_reg;
    logic [WORD_BITS-1:0] e_reg;
    logic [CW-1:0]        bit_reg;
    logic [WORD_BITS-1:0] base_reg;
    logic [WORD_BITS-1:0] res_reg;
    logic [WORD_BITS-1:0] opa_reg;
    logic [WORD_BITS-1:0] opb_reg;
    logic                 start_reg;
    logic                 start_next;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] out_data_reg;

    mul_status_t          mul_status;
    logic [WORD_BITS-1:0] product;
    logic                 in_accept;
    logic                 out_free;
    logic [WORD_BITS-1:0] init_r;

    meu_mulmod #(
        .WORD_BITS (WORD_BITS)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .op_a    (opa_reg),
        .op_b    (opb_reg),
        .modulus (modulus_reg),
        .status  (mul_status),
        .product (product)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;
    assign init_r        = (modulus_reg == ONE) ? '0 : ONE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'(out_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= ONE;
            modulus_reg  <= ONE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_EXPONENT:
                begin
                    exponent_reg <= cfg_data;
                end
                CFG_MODULUS:
                begin
                    if (cfg_data != '0)
                    begin
                        modulus_reg <= cfg_data;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                start_next = in_accept && (exponent_reg != '0);
            end
            ST_REDUCE:
            begin
                start_next = mul_status.done;
            end
            ST_SQUARE:
            begin
                start_next = mul_status.done && (e_reg[WORD_BITS-1] || (bit_reg != '0));
            end
            ST_MULT:
            begin
                start_next = mul_status.done && (bit_reg != '0);
            end
            default:
            begin
                start_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            start_reg <= start_next;
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (exponent_reg == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                ST_REDUCE:
                begin
                    if (mul_status.done)
                    begin
                        bit_reg   <= CW'(WORD_BITS - 1);
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE:
                begin
                    if (mul_status.done)
                    begin
                        if (e_reg[WORD_BITS-1])
                        begin
                            state_reg <= ST_MULT;
                        end
                        else if (bit_reg == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            bit_reg <= bit_reg - 1'b1;
                        end
                    end
                end
                ST_MULT:
                begin
                    if (mul_status.done)
                    begin
                        if (bit_reg == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            bit_reg   <= bit_reg - 1'b1;
                            state_reg <= ST_SQUARE;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    e_reg   <= exponent_reg;
                    opa_reg <= ONE;
                    opb_reg <= s_axis_tdata[WORD_BITS-1:0];
                    res_reg <= ONE;
                end
            end
            ST_REDUCE:
            begin
                if (mul_status.done)
                begin
                    base_reg <= product;
                    res_reg  <= init_r;
                    opa_reg  <= init_r;
                    opb_reg  <= init_r;
                end
            end
            ST_SQUARE:
            begin
                if (mul_status.done)
                begin
                    res_reg <= product;
                    if (e_reg[WORD_BITS-1])
                    begin
                        opa_reg <= product;
                        opb_reg <= base_reg;
                    end
                    else
                    begin
                        e_reg   <= {e_reg[WORD_BITS-2:0], 1'b0};
                        opa_reg <= product;
                        opb_reg <= product;
                    end
                end
            end
            ST_MULT:
            begin
                if (mul_status.done)
                begin
                    res_reg <= product;
                    e_reg   <= {e_reg[WORD_BITS-2:0], 1'b0};
                    opa_reg <= product;
                    opb_reg <= product;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
